### sv/lis_pkg.sv
// Shared types, character codes and control codes for the line indent shifter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lis_pkg;

	localparam int WS_DEPTH_DEF = 32;
	localparam int MAX_RESULTS  = 50;
	localparam int RC_W         = $clog2(MAX_RESULTS + 1);
	localparam int TW_MAX       = 16;
	localparam int TOTAL_W      = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_NONE  = 8'd0;

	localparam logic DIR_RIGHT = 1'b0;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BY_TAB_STOP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_TABS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH   = 2'd3;
	localparam logic [4:0] TAB_WIDTH_RST = 5'd8;

	// Source of the flush length.
	localparam logic [1:0] FL_ALL  = 2'd0;
	localparam logic [1:0] FL_KEEP = 2'd1;
	localparam logic [1:0] FL_WORK = 2'd2;

	// Filler emitted after the flush.
	localparam logic [1:0] FILL_NONE  = 2'd0;
	localparam logic [1:0] FILL_SPACE = 2'd1;
	localparam logic [1:0] FILL_TAB   = 2'd2;
	localparam logic [1:0] FILL_WORK  = 2'd3;

	// What an emit command puts into the output register.
	localparam logic [1:0] EM_TAB   = 2'd0;
	localparam logic [1:0] EM_FLUSH = 2'd1;
	localparam logic [1:0] EM_FILL  = 2'd2;
	localparam logic [1:0] EM_FINAL = 2'd3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_char;
		logic               char_valid;
		logic               text_done;
		logic               last_of_run;
		logic               line_overflow;
		logic [TOTAL_W-1:0] total_length;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       ws_push;
		logic       div_start;
		logic       ls_init;
		logic       ls_read;
		logic       ls_exec;
		logic       fl_setup;
		logic [1:0] fl_sel;
		logic [1:0] fill_sel;
		logic       fl_read;
		logic       emit;
		logic [1:0] emit_sel;
	} cmd_t;

	typedef struct packed {
		logic is_eot;
		logic is_nl;
		logic is_ws;
		logic in_body;
		logic ws_full;
		logic ws_empty;
		logic rem_ok;
		logic fold;
		logic shift_left;
		logic by_tab_stop;
		logic out_free;
		logic ls_need_ex;
		logic ls_last;
		logic fl_done;
		logic fill_done;
	} stat_t;

endpackage

`default_nettype wire

### sv/lis_rem_unit.sv
// Bit-serial remainder unit: column modulo tab width, one dividend bit per cycle.
// Uses no package items; instantiated by the datapath.
`default_nettype none

module lis_rem_unit #(
	parameter int VW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [VW-1:0] dividend,
	input  wire logic [4:0]    divisor,
	output logic               done,
	output logic [4:0]         rem
);

	localparam int CNT_W = $clog2(VW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    val_q;
	logic [3:0]       acc_q;
	logic [4:0]       acc_sh;
	logic [4:0]       acc_nx;

	assign acc_sh = {acc_q, val_q[VW-1]};
	assign acc_nx = (acc_sh >= divisor) ? acc_sh - divisor : acc_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= dividend;
			acc_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			acc_q <= acc_nx[3:0];
		end
	end

	assign done = done_q;
	assign rem  = {1'b0, acc_q};

endmodule

`default_nettype wire

### sv/lis_datapath.sv
// Datapath: configuration registers, whitespace buffer memory, line state, left shift
// working registers and the output register. Depends on lis_pkg and lis_rem_unit.
`default_nettype none

module lis_datapath #(
	parameter int WS_DEPTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lis_pkg::item_t                   in_item,
	input  wire logic                             cfg_we,
	input  wire logic [lis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lis_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire lis_pkg::cmd_t                    cmd,
	output lis_pkg::stat_t                        stat,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output lis_pkg::result_t                      out_item
);

	import lis_pkg::*;

	localparam int AW   = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
	localparam int CNTW = $clog2(WS_DEPTH + 1);
	localparam int CW   = $clog2(WS_DEPTH * TW_MAX + 1);
	localparam int XW   = (CNTW > 5) ? CNTW : 5;
	localparam int KW   = 5;

	logic            shift_left_q;
	logic            by_tab_stop_q;
	logic            allow_tabs_q;
	logic [4:0]      tab_width_q;

	item_t           item_q;
	logic            ws_kind_mem [WS_DEPTH];
	logic            rdata_q;

	logic [CNTW-1:0] ws_count_q;
	logic [CW-1:0]   wc_q;
	logic [CW-1:0]   cbt_q;
	logic [4:0]      rem_q;
	logic            rem_ok_q;
	logic            body_q;
	logic            ovf_pass_q;
	logic [TOTAL_W-1:0] total_q;
	logic [RC_W-1:0] rc_q;

	logic [CNTW-1:0] m_q;
	logic [KW-1:0]   k_q;
	logic [CW-1:0]   ww_q;
	logic [4:0]      step_q;

	logic [CNTW-1:0] fl_len_q;
	logic [CNTW-1:0] fl_idx_q;
	logic [KW-1:0]   fill_q;
	logic            fill_tab_q;

	logic            out_valid_q;
	result_t         out_q;

	logic [4:0]      tw;
	logic [4:0]      steps;
	logic            is_eot, is_nl, is_ws, is_tab, ws_full, run_ovf;
	logic [XW-1:0]   wsx, twm1, keepx;
	logic [CNTW-1:0] keep;
	logic [CNTW-1:0] m_dec;
	logic [CNTW-1:0] rd_idx;
	logic            rd_en;
	logic            ls_need_ex;
	logic [CW:0]     ls_lim;
	logic [CW:0]     ls_wwx;
	logic            out_free;
	logic            keep_res;
	logic            is_final;
	logic [TOTAL_W-1:0] total_nx;
	result_t         res;
	logic            div_done;
	logic [4:0]      div_rem;
	logic [4:0]      rem_inc;

	always_comb begin
		if (tab_width_q == 5'd0) begin
			tw = 5'd1;
		end else if (tab_width_q > 5'(TW_MAX)) begin
			tw = 5'(TW_MAX);
		end else begin
			tw = tab_width_q;
		end
	end

	assign steps   = by_tab_stop_q ? tw : 5'd1;
	assign is_eot  = item_q.end_of_text;
	assign is_nl   = (item_q.in_char == CH_NL);
	assign is_tab  = (item_q.in_char == CH_TAB);
	assign is_ws   = is_tab || (item_q.in_char == CH_SPACE);
	assign ws_full = (ws_count_q == CNTW'(WS_DEPTH));
	assign run_ovf = ovf_pass_q || (is_ws && ws_full);
	assign rem_inc = rem_q + 5'd1;

	assign wsx   = XW'(ws_count_q);
	assign twm1  = XW'(tw) - XW'(1);
	assign keepx = (wsx >= twm1) ? wsx - twm1 : '0;
	assign keep  = keepx[CNTW-1:0];

	assign m_dec      = m_q - CNTW'(1);
	assign ls_need_ex = (k_q == '0) && (m_q != '0);
	assign ls_lim     = {1'b0, cbt_q} + (CW+1)'(step_q);
	assign ls_wwx     = {1'b0, ww_q};

	assign rd_idx = cmd.ls_read ? m_dec : fl_idx_q;
	assign rd_en  = cmd.fl_read || (cmd.ls_read && ls_need_ex);

	assign out_free = !out_valid_q || !out_stall;
	assign keep_res = (rc_q < RC_W'(MAX_RESULTS));
	assign is_final = (cmd.emit_sel == EM_FINAL);

	lis_rem_unit #(
		.VW(CW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(wc_q),
		.divisor (tw),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_comb begin
		case (cmd.emit_sel)
			EM_TAB:   res.out_char = CH_TAB;
			EM_FLUSH: res.out_char = rdata_q ? CH_TAB : CH_SPACE;
			EM_FILL:  res.out_char = fill_tab_q ? CH_TAB : CH_SPACE;
			EM_FINAL: res.out_char = is_eot ? CH_NONE : item_q.in_char;
			default:  res.out_char = CH_NONE;
		endcase
		res.char_valid    = !(is_final && is_eot);
		res.text_done     = is_final && is_eot;
		res.last_of_run   = is_final || (rc_q == RC_W'(MAX_RESULTS - 1));
		res.line_overflow = run_ovf && !(is_final && is_eot);
		if (res.char_valid && (total_q != TOTAL_MAX)) begin
			total_nx = total_q + TOTAL_W'(1);
		end else begin
			total_nx = total_q;
		end
		res.total_length = total_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_left_q  <= 1'b0;
			by_tab_stop_q <= 1'b0;
			allow_tabs_q  <= 1'b1;
			tab_width_q   <= TAB_WIDTH_RST;
			ws_count_q    <= '0;
			wc_q          <= '0;
			cbt_q         <= '0;
			rem_q         <= '0;
			rem_ok_q      <= 1'b1;
			body_q        <= 1'b0;
			ovf_pass_q    <= 1'b0;
			total_q       <= '0;
			rc_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SHIFT_LEFT:  shift_left_q  <= cfg_data[0];
					REG_BY_TAB_STOP: by_tab_stop_q <= cfg_data[0];
					REG_ALLOW_TABS:  allow_tabs_q  <= cfg_data[0];
					REG_TAB_WIDTH: begin
						tab_width_q <= cfg_data;
						rem_ok_q    <= 1'b0;
					end
					default: ;
				endcase
			end

			if (div_done) begin
				rem_q    <= div_rem;
				rem_ok_q <= 1'b1;
			end

			if (cmd.ws_push) begin
				ws_count_q <= ws_count_q + CNTW'(1);
				if (is_tab) begin
					cbt_q <= wc_q;
					wc_q  <= wc_q - CW'(rem_q) + CW'(tw);
					rem_q <= '0;
				end else begin
					wc_q  <= wc_q + CW'(1);
					rem_q <= (rem_inc == tw) ? 5'd0 : rem_inc;
				end
			end

			if (cmd.emit) begin
				if (keep_res) begin
					total_q <= total_nx;
					rc_q    <= rc_q + RC_W'(1);
				end
				if (is_final) begin
					rc_q <= '0;
					if (is_eot || is_nl) begin
						ws_count_q <= '0;
						wc_q       <= '0;
						cbt_q      <= '0;
						rem_q      <= '0;
						rem_ok_q   <= 1'b1;
						body_q     <= 1'b0;
						ovf_pass_q <= 1'b0;
						if (is_eot) begin
							total_q <= '0;
						end
					end else if (body_q || ovf_pass_q) begin
						body_q <= body_q;
					end else if (is_ws) begin
						ovf_pass_q <= 1'b1;
						ws_count_q <= '0;
					end else begin
						body_q <= 1'b1;
					end
				end
			end

			if (cmd.emit && keep_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ws_push) begin
			ws_kind_mem[ws_count_q[AW-1:0]] <= is_tab;
		end
		if (rd_en) begin
			rdata_q <= ws_kind_mem[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end

		if (cmd.ls_init) begin
			m_q    <= ws_count_q;
			k_q    <= '0;
			ww_q   <= wc_q;
			step_q <= 5'd1;
		end else if (cmd.ls_read && !ls_need_ex) begin
			step_q <= step_q + 5'd1;
			if (k_q != '0) begin
				k_q <= k_q - KW'(1);
			end
		end else if (cmd.ls_exec) begin
			m_q    <= m_dec;
			step_q <= step_q + 5'd1;
			if (rdata_q) begin
				if (ls_wwx > ls_lim) begin
					k_q  <= KW'(ls_wwx - ls_lim);
					ww_q <= ww_q - CW'(step_q);
				end else begin
					ww_q <= cbt_q;
				end
			end
		end

		if (cmd.fl_setup) begin
			fl_idx_q <= '0;
			case (cmd.fl_sel)
				FL_ALL:  fl_len_q <= ws_count_q;
				FL_KEEP: fl_len_q <= keep;
				FL_WORK: fl_len_q <= m_q;
				default: fl_len_q <= ws_count_q;
			endcase
			case (cmd.fill_sel)
				FILL_NONE: begin
					fill_q     <= '0;
					fill_tab_q <= 1'b0;
				end
				FILL_SPACE: begin
					fill_q     <= KW'(1);
					fill_tab_q <= 1'b0;
				end
				FILL_TAB: begin
					fill_q     <= KW'(1);
					fill_tab_q <= 1'b1;
				end
				FILL_WORK: begin
					fill_q     <= k_q;
					fill_tab_q <= 1'b0;
				end
				default: begin
					fill_q     <= '0;
					fill_tab_q <= 1'b0;
				end
			endcase
		end else if (cmd.emit && cmd.emit_sel == EM_FLUSH) begin
			fl_idx_q <= fl_idx_q + CNTW'(1);
		end else if (cmd.emit && cmd.emit_sel == EM_FILL) begin
			fill_q <= fill_q - KW'(1);
		end

		if (cmd.emit && keep_res) begin
			out_q <= res;
		end
	end

	always_comb begin
		stat.is_eot      = is_eot;
		stat.is_nl       = is_nl;
		stat.is_ws       = is_ws;
		stat.in_body     = body_q || ovf_pass_q;
		stat.ws_full     = ws_full;
		stat.ws_empty    = (ws_count_q == '0);
		stat.rem_ok      = rem_ok_q;
		stat.fold        = allow_tabs_q && (rem_inc == tw);
		stat.shift_left  = shift_left_q;
		stat.by_tab_stop = by_tab_stop_q;
		stat.out_free    = out_free;
		stat.ls_need_ex  = ls_need_ex;
		stat.ls_last     = (step_q == steps);
		stat.fl_done     = (fl_idx_q == fl_len_q);
		stat.fill_done   = (fill_q == '0);
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

### sv/lis_ctrl.sv
// Controller state machine: sequences decode, left shift steps, flush and emission.
// Depends on lis_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module lis_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire lis_pkg::stat_t stat,
	output lis_pkg::cmd_t       cmd
);

	import lis_pkg::*;

	localparam logic [3:0] S_START   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DECODE  = 4'd2;
	localparam logic [3:0] S_DIV     = 4'd3;
	localparam logic [3:0] S_LS_RD   = 4'd4;
	localparam logic [3:0] S_LS_EX   = 4'd5;
	localparam logic [3:0] S_LS_DONE = 4'd6;
	localparam logic [3:0] S_PRE     = 4'd7;
	localparam logic [3:0] S_FL_RD   = 4'd8;
	localparam logic [3:0] S_FL_WR   = 4'd9;
	localparam logic [3:0] S_FILL    = 4'd10;
	localparam logic [3:0] S_FINAL   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       right;
	logic       ws_line;

	assign right   = (stat.shift_left == DIR_RIGHT);
	assign ws_line = right && stat.by_tab_stop && !stat.ws_empty;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_START: begin
				state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.in_body && (stat.is_eot || stat.is_nl) && ws_line) begin
					cmd.fl_setup = 1'b1;
					cmd.fl_sel   = FL_ALL;
					cmd.fill_sel = FILL_NONE;
					state_nx     = S_PRE;
				end else if (stat.is_eot || stat.in_body || stat.is_nl) begin
					if (stat.out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EM_FINAL;
						state_nx     = S_IDLE;
					end else begin
						state_nx = S_FINAL;
					end
				end else if (stat.is_ws) begin
					if (stat.ws_full) begin
						cmd.fl_setup = 1'b1;
						cmd.fl_sel   = FL_ALL;
						cmd.fill_sel = FILL_NONE;
						state_nx     = S_FL_RD;
					end else if (!stat.rem_ok) begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIV;
					end else begin
						cmd.ws_push = 1'b1;
						state_nx    = S_IDLE;
					end
				end else if (right && stat.by_tab_stop) begin
					cmd.fl_setup = 1'b1;
					cmd.fl_sel   = FL_ALL;
					cmd.fill_sel = FILL_NONE;
					state_nx     = S_PRE;
				end else if (right && !stat.rem_ok) begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end else if (right && stat.fold) begin
					cmd.fl_setup = 1'b1;
					cmd.fl_sel   = FL_KEEP;
					cmd.fill_sel = FILL_TAB;
					state_nx     = S_FL_RD;
				end else if (right) begin
					cmd.fl_setup = 1'b1;
					cmd.fl_sel   = FL_ALL;
					cmd.fill_sel = FILL_SPACE;
					state_nx     = S_FL_RD;
				end else begin
					cmd.ls_init = 1'b1;
					state_nx    = S_LS_RD;
				end
			end
			S_DIV: begin
				if (stat.rem_ok) begin
					state_nx = S_DECODE;
				end
			end
			S_LS_RD: begin
				cmd.ls_read = 1'b1;
				if (stat.ls_need_ex) begin
					state_nx = S_LS_EX;
				end else if (stat.ls_last) begin
					state_nx = S_LS_DONE;
				end
			end
			S_LS_EX: begin
				cmd.ls_exec = 1'b1;
				state_nx    = stat.ls_last ? S_LS_DONE : S_LS_RD;
			end
			S_LS_DONE: begin
				cmd.fl_setup = 1'b1;
				cmd.fl_sel   = FL_WORK;
				cmd.fill_sel = FILL_WORK;
				state_nx     = S_FL_RD;
			end
			S_PRE: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_TAB;
					state_nx     = S_FL_RD;
				end
			end
			S_FL_RD: begin
				if (stat.fl_done) begin
					state_nx = S_FILL;
				end else begin
					cmd.fl_read = 1'b1;
					state_nx    = S_FL_WR;
				end
			end
			S_FL_WR: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_FLUSH;
					state_nx     = S_FL_RD;
				end
			end
			S_FILL: begin
				if (stat.fill_done) begin
					state_nx = S_FINAL;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_FILL;
				end
			end
			S_FINAL: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_FINAL;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

### sv/line_indent_shifter_core.sv
// Top level of the line indent shifter: joins controller and datapath.
// Depends on lis_pkg, lis_ctrl, lis_datapath and lis_rem_unit.
//
// Text arrives one byte per item on in_valid/in_stall/in_item; results leave one per
// item on out_valid/out_stall/out_item, each carrying its byte, flags and running total.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. An item is
// taken while the controller is in S_IDLE and decoded in the cycle after. A passed
// byte is written into the output register from the decode state, or from S_FINAL
// while that register is still held. The first other byte of a line flushes the
// buffered whitespace from the buffer memory; each read is registered in S_FL_RD
// before it is emitted in S_FL_WR. A left shift first walks back over the buffer
// one column at a time through S_LS_RD and, where a buffered byte is read, S_LS_EX.
// After a change of tab width, the next buffered space or tab, or the first byte of
// a line shifted right by one column, waits in S_DIV on the serial remainder unit.
// After reset the configuration takes its default values, the line is empty and the
// input is stalled in S_START. A stalled output holds its item and halts emission;
// the output register lets the block prepare the next result meanwhile.

`default_nettype none

module line_indent_shifter_core #(
	parameter int WS_DEPTH = lis_pkg::WS_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire lis_pkg::item_t                 in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output lis_pkg::result_t                    out_item,
	input  wire logic                           cfg_we,
	input  wire logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lis_pkg::CFG_DATA_W-1:0] cfg_data
);

	import lis_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lis_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	lis_datapath #(
		.WS_DEPTH(WS_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("Result emitted while the output register was occupied.");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ws_push |-> (stat.rem_ok && !stat.ws_full))
		else $error("Whitespace buffered into a full buffer or with a stale remainder.");

	a_end_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.text_done) |->
		(!out_item.char_valid && out_item.last_of_run && !out_item.line_overflow))
		else $error("End marker carries a byte, an overflow flag or is not last.");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> in_stall)
		else $error("A new item was taken before the previous one was decoded.");

endmodule

`default_nettype wire
